[rtl/smjt_pkg.sv]
// shared types, constants and helpers for the smootherstep joint trajectory block
// no dependencies; imported by every module under rtl
package smjt_pkg;

    localparam int JOINTS    = 3;
    localparam int IO_JOINTS = 3;
    localparam int ANGLE_W   = 15;
    localparam int DIFF_W    = ANGLE_W + 1;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 11;
    localparam int T_W       = 16;
    localparam int S_W       = 17;
    localparam int P_W       = 20;
    localparam int MUL_W     = P_W + T_W;
    localparam int SPEED_W   = 8;
    localparam int REQ_W     = 2;

    // input beat layout
    localparam int NOW_LSB   = 0;
    localparam int TGT_LSB   = NOW_LSB + TIME_W;
    localparam int SPEED_LSB = TGT_LSB + IO_JOINTS * ANGLE_W;
    localparam int IN_W      = ((SPEED_LSB + SPEED_W + 7) / 8) * 8;
    localparam int OUT_W     = ((IO_JOINTS * ANGLE_W + 1 + 7) / 8) * 8;

    localparam logic [DUR_W-1:0] DUR_SLOW = DUR_W'(2000);
    // floor(x/17) == (x * RECIP_17) >> 20 for x below 2^20
    localparam int RECIP_17   = 61681;
    localparam int SCALED_W   = 31;
    localparam int RECIP_SH   = 20;
    localparam logic [S_W-1:0] ONE_Q16 = S_W'(65536);
    localparam logic [P_W:0]   P_BASE  = (P_W + 1)'(655360);
    localparam logic signed [ANGLE_W-1:0] HOME_LAST = ANGLE_W'(5760);

    typedef enum logic [REQ_W-1:0] {
        REQ_INIT = 2'd0,
        REQ_SET  = 2'd1,
        REQ_TICK = 2'd2
    } t_req;

    typedef struct packed {
        logic init;
        logic set;
        logic snap;
        logic mul;
        logic add;
    } t_lane_cmd;

    function automatic logic signed [ANGLE_W-1:0] f_home(input int j);
        f_home = (j == 2) ? HOME_LAST : '0;
    endfunction

endpackage

[rtl/smootherstep_joint_trajectory_top.sv]
// top level: request decode, sequencer, joint lanes and output register
// depends on smjt_pkg, smjt_div, smjt_ease, smjt_lane
//
// channel   dir  signals                          payload
// s         in   i_s_tvalid/o_s_tready            tdata: now, targets, speed; tuser: req
// m         out  o_m_tvalid/i_m_tready            tdata: coxa, femur, tibia, done
//
// set target is done in the accept cycle; init and the tick that ends a move go on to the output stage
// a tick inside a move passes through the accept, the serial divider for t, the shared
// ease multiplier, the lane blend (multiply, then add) and the output stage
// reset is synchronous and active low; pose returns to 0, 0, 90 degrees
// a stalled output holds its beat; a new input beat is taken meanwhile and its
// result waits in the output stage until the register frees
module smootherstep_joint_trajectory_top
    import smjt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // [31:0] now_ms, [46:32] target_coxa, [61:47] target_femur,
    // [76:62] target_tibia, [84:77] speed, [87:85] zero
    input  logic [IN_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0] i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [14:0] coxa_angle, [29:15] femur_angle, [44:30] tibia_angle,
    // [45] motion_done, [47:46] zero
    output logic [OUT_W-1:0] o_m_tdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_EASE = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state             r_state,      n_state;
    logic               r_moving,     n_moving;
    logic [TIME_W-1:0]  r_start_time, n_start_time;
    logic [DUR_W-1:0]   r_duration,   n_duration;
    logic               r_out_valid,  n_out_valid;
    logic [OUT_W-1:0]   r_out_data,   n_out_data;

    logic                      w_accept;
    t_req                      w_req;
    logic [TIME_W-1:0]         w_now;
    logic [SPEED_W-1:0]        w_speed;
    logic [TIME_W-1:0]         w_elapsed;
    logic                      w_expired;
    logic [SCALED_W-1:0]       w_scaled;
    logic [DUR_W-1:0]          w_new_dur;
    logic                      w_out_free;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [T_W-1:0]            w_quot;
    logic                      w_ease_start;
    logic                      w_ease_done;
    logic [S_W-1:0]            w_s;
    t_lane_cmd                 w_cmd;
    logic [OUT_W-1:0]          w_out_pack;
    logic signed [ANGLE_W-1:0] w_target_io [IO_JOINTS];
    logic signed [ANGLE_W-1:0] w_pose      [JOINTS];
    logic signed [ANGLE_W-1:0] w_io_pose   [IO_JOINTS];

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_req      = t_req'(i_s_tuser);
    assign w_now      = i_s_tdata[NOW_LSB +: TIME_W];
    assign w_speed    = i_s_tdata[SPEED_LSB +: SPEED_W];

    assign w_elapsed = w_now - r_start_time;
    assign w_expired = w_elapsed >= TIME_W'(r_duration);

    // speed*1920/255 is speed*128/17
    assign w_scaled  = SCALED_W'({w_speed, 7'b0}) * SCALED_W'(RECIP_17);
    assign w_new_dur = DUR_SLOW - w_scaled[RECIP_SH +: DUR_W];

    assign w_out_free = !r_out_valid || i_m_tready;

    genvar j;
    generate
        for (j = 0; j < IO_JOINTS; j++) begin : g_io
            assign w_target_io[j] = $signed(i_s_tdata[TGT_LSB + j*ANGLE_W +: ANGLE_W]);
            if (j < JOINTS) begin : g_used
                assign w_io_pose[j] = w_pose[j];
            end else begin : g_pad
                assign w_io_pose[j] = '0;
            end
        end

        for (j = 0; j < JOINTS; j++) begin : g_lane
            logic signed [ANGLE_W-1:0] w_tgt;
            if (j < IO_JOINTS) begin : g_tgt
                assign w_tgt = w_target_io[j];
            end else begin : g_zero
                assign w_tgt = '0;
            end
            smjt_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (w_cmd),
                .i_home   (f_home(j)),
                .i_target (w_tgt),
                .i_s      (w_s),
                .o_pose   (w_pose[j])
            );
        end
    endgenerate

    smjt_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_elapsed (w_elapsed[DUR_W-1:0]),
        .i_dur     (r_duration),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    smjt_ease u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ease_start),
        .i_t     (w_quot),
        .o_done  (w_ease_done),
        .o_s     (w_s)
    );

    // merge the lanes into one beat
    always_comb begin
        w_out_pack = '0;
        for (int k = 0; k < IO_JOINTS; k++) begin
            w_out_pack[k*ANGLE_W +: ANGLE_W] = w_io_pose[k];
        end
        w_out_pack[IO_JOINTS*ANGLE_W] = ~r_moving;
    end

    always_comb begin
        n_state      = r_state;
        n_moving     = r_moving;
        n_start_time = r_start_time;
        n_duration   = r_duration;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        w_cmd        = '0;
        w_div_start  = 1'b0;
        w_ease_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_req)
                        REQ_INIT: begin
                            w_cmd.init = 1'b1;
                            n_moving   = 1'b0;
                            n_state    = ST_OUT;
                        end
                        REQ_SET: begin
                            w_cmd.set    = 1'b1;
                            n_start_time = w_now;
                            n_duration   = w_new_dur;
                            n_moving     = 1'b1;
                        end
                        REQ_TICK: begin
                            if (r_moving) begin
                                if (w_expired) begin
                                    w_cmd.snap = 1'b1;
                                    n_moving   = 1'b0;
                                    n_state    = ST_OUT;
                                end else begin
                                    w_div_start = 1'b1;
                                    n_state     = ST_DIV;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_ease_start = 1'b1;
                    n_state      = ST_EASE;
                end
            end
            ST_EASE: begin
                if (w_ease_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                w_cmd.add = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_out_pack;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_moving     <= 1'b0;
            r_start_time <= '0;
            r_duration   <= DUR_W'(500);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_moving     <= n_moving;
            r_start_time <= n_start_time;
            r_duration   <= n_duration;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_init_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_req == REQ_INIT |=> r_state == ST_OUT)
        else $error("init beat did not go to the output stage");

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT && w_out_free |=> r_out_valid && r_state == ST_IDLE)
        else $error("output stage did not load its beat");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_ease_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ease_done |-> r_state == ST_EASE)
        else $error("ease unit finished outside the ease phase");

    a_blend_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL || r_state == ST_ADD |-> r_moving)
        else $error("blend step with no move active");

endmodule

[rtl/smjt_div.sv]
// restoring divider: quotient of (elapsed << 16) / duration, one bit per cycle
// depends on smjt_pkg
module smjt_div
    import smjt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DUR_W-1:0] i_elapsed,
    input  logic [DUR_W-1:0] i_dur,
    output logic             o_done,
    output logic [T_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(T_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_dur;
    logic [T_W-1:0]   r_quot;
    logic [DUR_W:0]   w_shift;
    logic             w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_dur};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(T_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // elapsed is already below the duration
            r_rem <= i_elapsed;
            r_dur <= i_dur;
        end else if (r_busy) begin
            r_rem  <= w_ge ? DUR_W'(w_shift - {1'b0, r_dur}) : w_shift[DUR_W-1:0];
            r_quot <= {r_quot[T_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/smjt_ease.sv]
// smootherstep ease, Q0.16 t in and Q1.16 s out, over one shared multiplier, four steps
// depends on smjt_pkg
module smjt_ease
    import smjt_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [T_W-1:0] i_t,
    output logic           o_done,
    output logic [S_W-1:0] o_s
);

    logic             r_busy;
    logic             r_done;
    logic [1:0]       r_step;
    logic [T_W-1:0]   r_t;
    logic [P_W-1:0]   r_p;
    logic [MUL_W-1:0] r_prod;
    logic [S_W-1:0]   r_s;
    logic [P_W-1:0]   w_op_a;
    logic [T_W-1:0]   w_op_b;
    logic [MUL_W-1:0] w_prod;
    logic [T_W-1:0]   w_hi;
    logic [P_W:0]     w_p;
    logic [P_W-1:0]   w_s_raw;

    assign w_hi = r_prod[2*T_W-1:T_W];

    // 10 - 15t + 6t^2 stays positive over the whole range of t
    assign w_p = P_BASE + (P_W + 1)'({w_hi, 2'b0}) + (P_W + 1)'({w_hi, 1'b0})
               - (P_W + 1)'({r_t, 4'b0} - {4'b0, r_t});

    always_comb begin
        case (r_step)
            2'd0: begin
                w_op_a = P_W'(r_t);
                w_op_b = r_t;
            end
            2'd1: begin
                w_op_a = P_W'(w_hi);
                w_op_b = r_t;
            end
            default: begin
                w_op_a = r_p;
                w_op_b = w_hi;
            end
        endcase
    end

    assign w_prod  = w_op_a * w_op_b;
    assign w_s_raw = r_prod[MUL_W-1:T_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_t <= i_t;
        end else if (r_busy) begin
            if (r_step != 2'd3) begin
                r_prod <= w_prod;
            end
            if (r_step == 2'd1) begin
                r_p <= w_p[P_W-1:0];
            end
            if (r_step == 2'd3) begin
                r_s <= (w_s_raw > P_W'(ONE_Q16)) ? ONE_Q16 : w_s_raw[S_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_s    = r_s;

endmodule

[rtl/smjt_lane.sv]
// one joint: start, target and current angle, blend multiply and add
// depends on smjt_pkg
module smjt_lane
    import smjt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_cmd                 i_cmd,
    input  logic signed [ANGLE_W-1:0] i_home,
    input  logic signed [ANGLE_W-1:0] i_target,
    input  logic        [S_W-1:0]     i_s,
    output logic signed [ANGLE_W-1:0] o_pose
);

    localparam int PROD_W = S_W + 1 + DIFF_W;

    logic signed [ANGLE_W-1:0] r_start;
    logic signed [ANGLE_W-1:0] r_end;
    logic signed [ANGLE_W-1:0] r_cur;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [PROD_W-1:0]  w_prod;

    assign w_diff = DIFF_W'(r_end) - DIFF_W'(r_start);
    assign w_prod = $signed({1'b0, i_s}) * w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_cur   <= i_home;
        end else if (i_cmd.init) begin
            r_cur <= i_home;
        end else if (i_cmd.set) begin
            r_start <= r_cur;
            r_end   <= i_target;
        end else if (i_cmd.snap) begin
            r_cur <= r_end;
        end else if (i_cmd.add) begin
            // the blend lies between start and target, so 15 bits hold it
            r_cur <= r_start + $signed(r_prod[ANGLE_W+T_W-1:T_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
    end

    assign o_pose = r_cur;

endmodule

[sim/tb_top.sv]
// self-checking bench for smootherstep_joint_trajectory_top: directed and random
// set-target, tick, init and unused-request beats against a built-in trajectory predictor
// depends on rtl/smjt_pkg.sv and the rtl of the block
module tb_top;
    import smjt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned DUR_SPAN_MS = 1920;
    localparam int unsigned SPEED_TOP   = 255;
    localparam int unsigned Q16_ONE     = 65536;
    localparam int          MAX_REPORTS = 10;
    localparam int          RAND_ITEMS  = 1400;

    typedef struct {
        logic [ANGLE_W-1:0] coxa;
        logic [ANGLE_W-1:0] femur;
        logic [ANGLE_W-1:0] tibia;
        logic               done;
    } pose_beat_t;

    class trajectory_scoreboard;
        int          from_pose[JOINTS];
        int          to_pose[JOINTS];
        int          cur_pose[JOINTS];
        logic [31:0] start_ms;
        int unsigned move_ms;
        bit          moving;
        pose_beat_t  pose_q[$];
        int          mismatches;
        int          beats_seen;

        function new();
            for (int j = 0; j < JOINTS; j++) begin
                from_pose[j] = 0;
                to_pose[j]   = 0;
            end
            go_home();
            start_ms   = '0;
            move_ms    = 500;
            moving     = 1'b0;
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function void go_home();
            for (int j = 0; j < JOINTS; j++)
                cur_pose[j] = (j == 2) ? int'(HOME_LAST) : 0;
        endfunction

        function int pending();
            return pose_q.size();
        endfunction

        // quintic ease with truncation at every stage, result in q16
        function int unsigned smootherstep_q16(int unsigned t);
            longint unsigned tl, t2, t3, poly, s;
            tl   = t;
            t2   = (tl * tl) >> 16;
            t3   = (t2 * tl) >> 16;
            poly = 64'd655360 + 64'd6 * t2 - 64'd15 * tl;
            s    = (t3 * poly) >> 16;
            return (s > Q16_ONE) ? Q16_ONE : int'(s);
        endfunction

        function int lerp_angle(int a, int b, int unsigned s);
            longint prod;
            prod = longint'(s) * (longint'(b) - longint'(a));
            return a + int'(prod >>> 16);
        endfunction

        function void push_pose();
            pose_beat_t p;
            p.coxa  = ANGLE_W'(cur_pose[0]);
            p.femur = ANGLE_W'(cur_pose[1]);
            p.tibia = ANGLE_W'(cur_pose[2]);
            p.done  = !moving;
            pose_q.push_back(p);
        endfunction

        // returns 1 when the beat changed state or caused a result
        function bit note_input(logic [REQ_W-1:0] req, logic [31:0] now,
                                logic signed [ANGLE_W-1:0] tgt[JOINTS],
                                logic [SPEED_W-1:0] spd);
            logic [31:0]     elapsed;
            longint unsigned t_q16;
            int unsigned     s;
            case (req)
                REQ_INIT: begin
                    go_home();
                    moving = 1'b0;
                    push_pose();
                    return 1'b1;
                end
                REQ_SET: begin
                    for (int j = 0; j < JOINTS; j++) begin
                        from_pose[j] = cur_pose[j];
                        to_pose[j]   = int'(tgt[j]);
                    end
                    start_ms = now;
                    move_ms  = int'(DUR_SLOW) - (int'(spd) * DUR_SPAN_MS) / SPEED_TOP;
                    moving   = 1'b1;
                    return 1'b1;
                end
                REQ_TICK: begin
                    if (!moving)
                        return 1'b0;
                    elapsed = now - start_ms;
                    if (move_ms == 0 || elapsed >= move_ms) begin
                        for (int j = 0; j < JOINTS; j++)
                            cur_pose[j] = to_pose[j];
                        moving = 1'b0;
                    end else begin
                        t_q16 = (longint'(elapsed) << 16) / move_ms;
                        s = smootherstep_q16(int'(t_q16));
                        for (int j = 0; j < JOINTS; j++)
                            cur_pose[j] = lerp_angle(from_pose[j], to_pose[j], s);
                    end
                    push_pose();
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            pose_beat_t exp_p;
            pose_beat_t got;
            got.coxa  = d[ANGLE_W-1:0];
            got.femur = d[2*ANGLE_W-1:ANGLE_W];
            got.tibia = d[3*ANGLE_W-1:2*ANGLE_W];
            got.done  = d[3*ANGLE_W];
            beats_seen++;
            if (pose_q.size() == 0) begin
                flag($sformatf("beat %0d: unexpected result coxa %0d femur %0d tibia %0d done %0b",
                     beats_seen, $signed(got.coxa), $signed(got.femur),
                     $signed(got.tibia), got.done));
                return;
            end
            exp_p = pose_q.pop_front();
            if (got.coxa !== exp_p.coxa || got.femur !== exp_p.femur ||
                got.tibia !== exp_p.tibia || got.done !== exp_p.done)
                flag($sformatf({"beat %0d: expected coxa %0d femur %0d tibia %0d done %0b,",
                     " got coxa %0d femur %0d tibia %0d done %0b"}, beats_seen,
                     $signed(exp_p.coxa), $signed(exp_p.femur), $signed(exp_p.tibia),
                     exp_p.done, $signed(got.coxa), $signed(got.femur),
                     $signed(got.tibia), got.done));
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata;
    logic [REQ_W-1:0] i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    trajectory_scoreboard sb;
    int               counted = 0;
    int               burst_left = 0;
    logic [10:0]      stall_cnt = '0;

    smootherstep_joint_trajectory_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // receiver: always ready, coin flips, one in four, then long stalls
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1'b1;
        case (stall_cnt[10:9])
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= 1'($urandom_range(0, 1));
            2'd2: i_m_tready <= (stall_cnt[1:0] == 2'd0);
            default: i_m_tready <= (stall_cnt[5:3] == 3'd0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    task automatic put_request(input logic [REQ_W-1:0] req, input logic [31:0] now,
                               input logic [ANGLE_W-1:0] tc, input logic [ANGLE_W-1:0] tf,
                               input logic [ANGLE_W-1:0] tt, input logic [SPEED_W-1:0] spd);
        int gap;
        logic signed [ANGLE_W-1:0] tgt[JOINTS];
        tgt[0] = tc;
        tgt[1] = tf;
        tgt[2] = tt;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {3'b000, spd, tt, tf, tc, now};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        counted += sb.note_input(req, now, tgt, spd);
    endtask

    // unused payload fields carry noise
    task automatic tick_at(input logic [31:0] now);
        put_request(REQ_TICK, now, ANGLE_W'($urandom), ANGLE_W'($urandom),
                    ANGLE_W'($urandom), SPEED_W'($urandom));
    endtask

    function automatic logic [ANGLE_W-1:0] pick_angle();
        if ($urandom_range(0, 9) == 0)
            return ANGLE_W'($urandom);
        return ANGLE_W'($urandom_range(0, 23040) - 11520);
    endfunction

    task automatic set_target(input logic [31:0] now, input logic [SPEED_W-1:0] spd);
        put_request(REQ_SET, now, pick_angle(), pick_angle(), pick_angle(), spd);
    endtask

    // a well formed move: set, then ticks walking forward, mostly to or past the end
    task automatic run_move();
        logic [31:0]  base;
        logic [7:0]   spd;
        int unsigned  dur, el, step_max;
        base = $urandom;
        spd  = 8'($urandom_range(0, 255));
        set_target(base, spd);
        dur = sb.move_ms;
        step_max = (spd > 200 && $urandom_range(0, 4) == 0) ? dur / 40 + 1 : dur / 3 + 1;
        el = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, step_max);
        forever begin
            if (el >= dur && $urandom_range(0, 1) == 0)
                el = dur;
            tick_at(base + el);
            if (el >= dur || $urandom_range(0, 29) == 0)
                break;
            el += $urandom_range(0, step_max);
        end
        if ($urandom_range(0, 9) == 0)
            tick_at(base + el + $urandom_range(0, 50));
    endtask

    initial begin
        int pick;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= REQ_INIT;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        put_request(REQ_INIT, 32'h0, '0, '0, '0, 8'd0);
        tick_at(32'h0000_0040);
        put_request(REQ_UNUSED, 32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 8'hFF);
        put_request(REQ_SET, 32'h0000_1000, 15'h3FFF, 15'h4000, 15'sd11520, 8'd0);
        tick_at(32'h0000_1000);
        tick_at(32'h0000_1001);
        tick_at(32'h0000_1000 + 1000);
        tick_at(32'h0000_1000 + 1999);
        tick_at(32'h0000_1000 + 2000);
        tick_at(32'h0000_2000);
        // start just below the wrap point so the elapsed time rolls over
        put_request(REQ_SET, 32'hFFFF_FFC0, -15'sd11520, 15'sd11520, -15'sd1, 8'd255);
        tick_at(32'hFFFF_FFFF);
        tick_at(32'h0000_000F);
        put_request(REQ_UNUSED, 32'h0000_0010, '0, '0, '0, 8'd0);
        tick_at(32'h0000_0010);
        put_request(REQ_SET, 32'd100, '0, '0, '0, 8'd128);
        put_request(REQ_SET, 32'd150, 15'sd5000, -15'sd5000, 15'sd100, 8'd17);
        tick_at(32'd400);
        put_request(REQ_INIT, 32'd450, '0, '0, '0, 8'd0);
        tick_at(32'd500);
        put_request(REQ_SET, 32'd1000, 15'sd1, -15'sd1, '0, 8'd200);
        tick_at(32'd999);
        put_request(REQ_SET, 32'd0, 15'sd7, -15'sd7, 15'sd3, 8'd1);
        tick_at(32'h7FFF_FFFF);

        // random
        counted = 0;
        while (counted < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                run_move();
            else if (pick < 82)
                put_request(REQ_INIT, $urandom, pick_angle(), pick_angle(), pick_angle(),
                            SPEED_W'($urandom));
            else if (pick < 90) begin
                if ($urandom_range(0, 1) == 0)
                    tick_at($urandom);
                else
                    put_request(REQ_UNUSED, $urandom, ANGLE_W'($urandom), ANGLE_W'($urandom),
                                ANGLE_W'($urandom), SPEED_W'($urandom));
            end else begin
                set_target($urandom, SPEED_W'($urandom));
                repeat ($urandom_range(1, 3)) tick_at($urandom);
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
